### design/bnut_pkg.sv
// Shared constants, widths and helpers of the BDD node unique table.
`default_nettype none
package bnut_pkg;

  localparam int VAR_W          = 8;
  localparam int CHILD_W        = 12;
  localparam int KEY_W          = VAR_W + 2 * CHILD_W;
  localparam int NODE_COUNT_DEF = 4096;
  localparam int FIRST_FREE_ID  = 2;

  // Multiplicative hash constant (golden ratio, 32 bits)
  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

  typedef logic [KEY_W-1:0] key_t;

  function automatic key_t pack_key(input logic [VAR_W-1:0]   v,
                                    input logic [CHILD_W-1:0] lo,
                                    input logic [CHILD_W-1:0] hi);
    return {v, lo, hi};
  endfunction

endpackage
`default_nettype wire

### design/bnut_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface bnut_in_if;
  import bnut_pkg::*;
  logic               valid;
  logic               ready;
  logic [VAR_W-1:0]   var_index;
  logic [CHILD_W-1:0] low_child;
  logic [CHILD_W-1:0] high_child;

  modport source (output valid, output var_index, output low_child, output high_child,
                  input ready);
  modport sink   (input valid, input var_index, input low_child, input high_child,
                  output ready);
endinterface

interface bnut_out_if;
  import bnut_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHILD_W-1:0] node_id;
  logic               created;
  logic               table_full;

  modport source (output valid, output node_id, output created, output table_full,
                  input ready);
  modport sink   (input valid, input node_id, input created, input table_full,
                  output ready);
endinterface
`default_nettype wire

### design/bdd_node_unique_table_core.sv
// Top level of the BDD node unique table: sequencer, hash unit and bucket RAM.
//
//  channel | dir | payload                              | transfer when
//  --------+-----+--------------------------------------+------------------------
//  in_ch   | in  | var_index, low_child, high_child     | in_ch.valid & in_ch.ready
//  out_ch  | out | node_id, created, table_full         | out_ch.valid & out_ch.ready
//
// A request with equal children goes from IDLE straight to DONE; any other passes through
// SEED and then PROBE, which walks the bucket RAM with linear probes (one read port,
// one bucket a cycle). One request is in work at a time.
// After reset a clearing pass writes every bucket before the first request is taken.
// A stalled result waits in the output register while the next request is taken.
`default_nettype none
module bdd_node_unique_table_core #(
  parameter int NODE_COUNT = bnut_pkg::NODE_COUNT_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bnut_in_if.sink   in_ch,
  bnut_out_if.source out_ch
);
  import bnut_pkg::*;

  localparam int AW     = $clog2(NODE_COUNT);
  localparam int DEPTH  = 1 << AW;
  localparam int ENT_W  = 1 + KEY_W + AW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SEED  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [AW-1:0]      clr_r;
  logic [AW-1:0]      idx_r;
  logic [AW:0]        next_free_r;
  key_t               key_r;
  logic [CHILD_W-1:0] res_id_r;
  logic               res_created_r;
  logic               res_full_r;
  logic               out_valid_r;
  logic [CHILD_W-1:0] out_id_r;
  logic               out_created_r;
  logic               out_full_r;

  logic               in_xfer;
  logic               out_free;
  logic               full;
  logic [AW-1:0]      bucket;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;
  logic               ent_valid;
  key_t               ent_key;
  logic [AW-1:0]      ent_id;

  bnut_hash #(.IDX_W(AW)) u_hash (
    .clk    (clk),
    .en     (in_xfer),
    .key    (pack_key(in_ch.var_index, in_ch.low_child, in_ch.high_child)),
    .bucket (bucket)
  );

  bnut_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_buckets (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign full        = (next_free_r >= (AW+1)'(NODE_COUNT));

  assign ent_valid = ram_rdata[ENT_W-1];
  assign ent_key   = ram_rdata[ENT_W-2 -: KEY_W];
  assign ent_id    = ram_rdata[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {1'b1, key_r, next_free_r[AW-1:0]};
    ram_re    = 1'b0;
    ram_raddr = idx_r + AW'(1);
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == {AW{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_ch.low_child == in_ch.high_child) ? ST_DONE : ST_SEED;
        end
      end
      ST_SEED: begin
        ram_re    = 1'b1;
        ram_raddr = bucket;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (!ent_valid) begin
          ram_we    = !full;
          state_nxt = ST_DONE;
        end else if (ent_key == key_r) begin
          state_nxt = ST_DONE;
        end else begin
          // advance to the next bucket
          ram_re = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      next_free_r <= (AW+1)'(FIRST_FREE_ID);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + AW'(1);
      if (ram_we && state_r == ST_PROBE) next_free_r <= next_free_r + (AW+1)'(1);
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r         <= pack_key(in_ch.var_index, in_ch.low_child, in_ch.high_child);
      res_id_r      <= in_ch.low_child;
      res_created_r <= 1'b0;
      res_full_r    <= 1'b0;
    end
    if (state_r == ST_SEED) begin
      idx_r <= bucket;
    end else if (state_r == ST_PROBE) begin
      if (!ent_valid) begin
        res_id_r      <= full ? '0 : CHILD_W'(next_free_r);
        res_created_r <= !full;
        res_full_r    <= full;
      end else if (ent_key == key_r) begin
        res_id_r <= CHILD_W'(ent_id);
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
    if (state_r == ST_DONE && out_free) begin
      out_id_r      <= res_id_r;
      out_created_r <= res_created_r;
      out_full_r    <= res_full_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.node_id    = out_id_r;
  assign out_ch.created    = out_created_r;
  assign out_ch.table_full = out_full_r;

endmodule
`default_nettype wire

### design/bnut_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bnut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/bnut_hash.sv
// Registered multiplicative hash of a node triple down to a bucket index.
`default_nettype none
module bnut_hash #(
  parameter int IDX_W = 12
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire bnut_pkg::key_t   key,
  output logic      [IDX_W-1:0] bucket
);
  import bnut_pkg::*;

  key_t prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= key * HASH_MULT;
    end
  end

  // Take the top bits of the low product word
  assign bucket = prod_r[KEY_W-1 -: IDX_W];

endmodule
`default_nettype wire

### tb/bdd_node_unique_table_core_tb.sv
// Testbench for the BDD node unique table: predicts each node id and checks every result.
module bdd_node_unique_table_core_tb;
  import bnut_pkg::*;

  // Full-size store; lookups in the predictor go through an associative array.
  localparam int TABLE_NODES = NODE_COUNT_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int MAX_IDLE    = 13;

  typedef struct packed {
    logic [CHILD_W-1:0] node_id;
    logic               created;
    logic               table_full;
  } node_answer_t;

  logic clk;
  logic rst_n;

  bnut_in_if  in_ch();
  bnut_out_if out_ch();

  bdd_node_unique_table_core #(.NODE_COUNT(TABLE_NODES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted state of the node store
  int   id_of_triple[key_t];
  key_t triple_of_id[TABLE_NODES];
  int   free_id;

  node_answer_t pending_nodes[$];
  int           error_count;
  int           cycle_count;
  bit           source_steady;
  bit           sink_steady;
  int           hold_off_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_nodes.size());
      $display("** bdd_node_unique_table_core: FAILED **");
      $finish;
    end
  end

  // Hash-consing: equal children collapse, known triples reuse their id, new ones take
  // the next free id until the store runs out.
  function automatic node_answer_t canonical_node(input logic [VAR_W-1:0]   v,
                                                  input logic [CHILD_W-1:0] lo,
                                                  input logic [CHILD_W-1:0] hi);
    node_answer_t ans;
    key_t         triple;
    ans    = '0;
    triple = {v, lo, hi};
    if (lo == hi) begin
      ans.node_id = lo;
      return ans;
    end
    if (id_of_triple.exists(triple)) begin
      ans.node_id = id_of_triple[triple][CHILD_W-1:0];
      return ans;
    end
    if (free_id >= TABLE_NODES) begin
      ans.table_full = 1'b1;
      return ans;
    end
    id_of_triple[triple]  = free_id;
    triple_of_id[free_id] = triple;
    ans.node_id           = free_id[CHILD_W-1:0];
    ans.created           = 1'b1;
    free_id++;
    return ans;
  endfunction

  task automatic send_request(input logic [VAR_W-1:0]   v,
                              input logic [CHILD_W-1:0] lo,
                              input logic [CHILD_W-1:0] hi);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, MAX_IDLE);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.var_index  <= v;
    in_ch.low_child  <= lo;
    in_ch.high_child <= hi;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_nodes.push_back(canonical_node(v, lo, hi));
  endtask

  // Mix of collapsing requests, repeats of stored nodes, a small alphabet that
  // collides often, and fully random triples.
  task automatic send_mixed_request();
    int                 pick;
    int                 id;
    logic [VAR_W-1:0]   v;
    logic [CHILD_W-1:0] lo;
    logic [CHILD_W-1:0] hi;
    pick = $urandom_range(0, 99);
    v    = VAR_W'($urandom_range(0, 2**VAR_W - 1));
    lo   = CHILD_W'($urandom_range(0, 2**CHILD_W - 1));
    hi   = CHILD_W'($urandom_range(0, 2**CHILD_W - 1));
    if (pick < 12) begin
      hi = lo;
    end else if (pick < 45 && free_id > FIRST_FREE_ID) begin
      id = $urandom_range(FIRST_FREE_ID, free_id - 1);
      {v, lo, hi} = triple_of_id[id];
    end else if (pick < 75) begin
      v  = VAR_W'($urandom_range(0, 1));
      lo = CHILD_W'($urandom_range(0, 5));
      hi = CHILD_W'($urandom_range(0, 5));
    end
    send_request(v, lo, hi);
  endtask

  // Drop valid so the last request is not taken twice, then wait for all results.
  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_nodes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(8'd0,   12'd0,    12'd0);
    send_request(8'd255, 12'd4095, 12'd4095);
    send_request(8'd0,   12'd0,    12'd1);
    send_request(8'd0,   12'd0,    12'd1);
    send_request(8'd0,   12'd1,    12'd0);
    send_request(8'd1,   12'd0,    12'd1);
    send_request(8'd255, 12'd4095, 12'd0);
    send_request(8'd255, 12'd0,    12'd4095);
    send_request(8'd255, 12'd4095, 12'd4094);
    // children that name no stored node
    send_request(8'd128, 12'd2048, 12'd1);
    send_request(8'd77,  12'd3000, 12'd4000);
    send_request(8'd0,   12'd0,    12'd1);
    send_request(8'd255, 12'd4095, 12'd0);
    send_request(8'd7,   12'd3,    12'd3);
    send_request(8'd200, 12'd2,    12'd3);
    send_request(8'd200, 12'd2,    12'd3);
    send_request(8'd170, 12'd2730, 12'd1365);
    send_request(8'd85,  12'd1365, 12'd2730);
    wait_drain();
  endtask

  task automatic test_random_mix(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        source_steady = ($urandom_range(0, 3) == 0);
      send_mixed_request();
    end
    source_steady = 1'b0;
    wait_drain();
  endtask

  // Hold the result side off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    source_steady   = 1'b1;
    hold_off_cycles = 400;
    repeat (24) send_mixed_request();
    source_steady = 1'b0;
    wait_drain();
  endtask

  always @(posedge clk) begin : check_results
    node_answer_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_nodes.size() == 0) begin
        $error("result with nothing pending: node_id %0d created %0b table_full %0b",
               out_ch.node_id, out_ch.created, out_ch.table_full);
        error_count++;
      end else begin
        want = pending_nodes.pop_front();
        if (out_ch.node_id !== want.node_id) begin
          $error("node_id: expected %0d, got %0d", want.node_id, out_ch.node_id);
          error_count++;
        end
        if (out_ch.created !== want.created) begin
          $error("created: expected %0b, got %0b", want.created, out_ch.created);
          error_count++;
        end
        if (out_ch.table_full !== want.table_full) begin
          $error("table_full: expected %0b, got %0b", want.table_full, out_ch.table_full);
          error_count++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (sink_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0)
        sink_steady = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.var_index  = '0;
    in_ch.low_child  = '0;
    in_ch.high_child = '0;
    free_id          = FIRST_FREE_ID;
    error_count      = 0;
    cycle_count      = 0;
    source_steady    = 1'b0;
    sink_steady      = 1'b0;
    hold_off_cycles  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(480);
    test_backpressure();
    test_random_mix(330);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_drain();
    repeat (TABLE_NODES + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("** bdd_node_unique_table_core: PASSED **");
    end else begin
      $display("** bdd_node_unique_table_core: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
design/bnut_pkg.sv
design/bnut_if.sv
design/bnut_ram.sv
design/bnut_hash.sv
design/bdd_node_unique_table_core.sv
tb/bdd_node_unique_table_core_tb.sv
